[rtl/qer_pkg.sv]
package qer_pkg;

   localparam int COEF_W  = 16;
   localparam int POLY_W  = 48;
   localparam int ROOT_W  = 32;
   localparam int COUNT_W = 2;
   localparam int CSR_INDEX_W = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_QUAD  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_LIN   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COEF_CONST = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_NONE = 2'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE  = 2'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO  = 2'd2;
   localparam logic [COUNT_W-1:0] COUNT_ALL  = 2'd3;

   // Roots of the current coefficients, with the solver's busy flag.
   typedef struct packed {
      logic                      busy;
      logic [COUNT_W-1:0]        count;
      logic signed [ROOT_W-1:0]  low;
      logic signed [ROOT_W-1:0]  high;
   } root_info_type;

   // First stage: products with x.
   typedef struct packed {
      logic signed [COEF_W-1:0]   x;
      logic signed [2*COEF_W-1:0] ax;
      logic signed [2*COEF_W-1:0] bx;
   } prod_stage_type;

   // Second stage: exact sum with 24 fraction bits.
   typedef struct packed {
      logic signed [POLY_W-1:0] total;
   } sum_stage_type;

   // Last stage: polynomial value rounded down to 16 fraction bits.
   typedef struct packed {
      logic signed [POLY_W-1:0] poly;
   } out_stage_type;

endpackage

[rtl/qer_cell.sv]
module qer_cell #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff;
   logic             valid_in;
   logic [WIDTH-1:0] data_ff;
   logic [WIDTH-1:0] data_in;

   // The cell takes a new item whenever it is empty or its neighbour takes the one it holds.
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign data_in   = (in_ready && in_valid) ? in_data : data_ff;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

[rtl/qer_solver.sv]
module qer_solver (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [qer_pkg::COEF_W-1:0]  coef_quad,
   input  logic signed [qer_pkg::COEF_W-1:0]  coef_lin,
   input  logic signed [qer_pkg::COEF_W-1:0]  coef_const,
   output qer_pkg::root_info_type             info
);
   import qer_pkg::*;

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] S_IDLE = 3'd0;
   localparam logic [STATE_W-1:0] S_MUL  = 3'd1;
   localparam logic [STATE_W-1:0] S_DISC = 3'd2;
   localparam logic [STATE_W-1:0] S_PICK = 3'd3;
   localparam logic [STATE_W-1:0] S_SQRT = 3'd4;
   localparam logic [STATE_W-1:0] S_DIV  = 3'd5;

   localparam logic [1:0] PASS_LIN = 2'd0;
   localparam logic [1:0] PASS_LO  = 2'd1;
   localparam logic [1:0] PASS_HI  = 2'd2;

   localparam int DISC_W = 35;
   localparam int SQ_W   = 34;
   localparam int MAG_W  = 17;
   localparam int DVD_W  = MAG_W + 16;
   localparam int NUM_W  = 19;
   localparam int SQ_STEPS  = SQ_W / 2;
   localparam int DIV_STEPS = DVD_W;

   logic [STATE_W-1:0]        state_ff, state_in;
   logic [1:0]                pass_ff, pass_in;
   logic signed [31:0]        bb_ff, bb_in, ac_ff, ac_in;
   logic signed [DISC_W-1:0]  disc_ff, disc_in;
   logic [SQ_W-1:0]           n_ff, n_in, res_ff, res_in, bit_ff, bit_in;
   logic [4:0]                sq_cnt_ff, sq_cnt_in;
   logic                      neg_ff, neg_in;
   logic [DVD_W-1:0]          dvd_ff, dvd_in, quot_ff, quot_in;
   logic [MAG_W-1:0]          dvs_ff, dvs_in, rem_ff, rem_in;
   logic [5:0]                dv_cnt_ff, dv_cnt_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic signed [ROOT_W-1:0]  low_ff, low_in, high_ff, high_in;

   logic [SQ_W-1:0]           sq_sum;
   logic [MAG_W:0]            rem_sh;
   logic [MAG_W-1:0]          root_s;
   logic signed [NUM_W-1:0]   num_lo, num_hi, num_lin;
   logic signed [NUM_W-1:0]   den_quad, den_lin;
   logic signed [ROOT_W-1:0]  quot_sat;

   assign sq_sum  = res_ff + bit_ff;
   assign rem_sh  = {rem_ff, dvd_ff[DVD_W-1]};
   assign root_s  = res_ff[MAG_W-1:0];
   assign num_lo  = -NUM_W'(coef_lin) - NUM_W'({1'b0, root_s});
   assign num_hi  = -NUM_W'(coef_lin) + NUM_W'({1'b0, root_s});
   assign num_lin = -NUM_W'(coef_const);
   assign den_quad = NUM_W'(coef_quad) <<< 1;
   assign den_lin  = NUM_W'(coef_lin);

   function automatic logic [MAG_W-1:0] mag(input logic signed [NUM_W-1:0] v);
      logic signed [NUM_W-1:0] p;
      p = v[NUM_W-1] ? -v : v;
      return p[MAG_W-1:0];
   endfunction

   // Sign and saturation of the finished magnitude quotient.
   always_comb begin
      if (neg_ff) begin
         if (quot_ff > DVD_W'(33'h0_8000_0000)) begin
            quot_sat = {1'b1, {(ROOT_W-1){1'b0}}};
         end else begin
            quot_sat = -signed'(quot_ff[ROOT_W-1:0]);
         end
      end else begin
         if (quot_ff > DVD_W'(33'h0_7FFF_FFFF)) begin
            quot_sat = {1'b0, {(ROOT_W-1){1'b1}}};
         end else begin
            quot_sat = signed'(quot_ff[ROOT_W-1:0]);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      pass_in   = pass_ff;
      bb_in     = bb_ff;
      ac_in     = ac_ff;
      disc_in   = disc_ff;
      n_in      = n_ff;
      res_in    = res_ff;
      bit_in    = bit_ff;
      sq_cnt_in = sq_cnt_ff;
      neg_in    = neg_ff;
      dvd_in    = dvd_ff;
      quot_in   = quot_ff;
      dvs_in    = dvs_ff;
      rem_in    = rem_ff;
      dv_cnt_in = dv_cnt_ff;
      count_in  = count_ff;
      low_in    = low_ff;
      high_in   = high_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            bb_in    = 32'(coef_lin) * 32'(coef_lin);
            ac_in    = 32'(coef_quad) * 32'(coef_const);
            low_in   = '0;
            high_in  = '0;
            state_in = S_DISC;
         end
         S_DISC: begin
            disc_in  = DISC_W'(bb_ff) - (DISC_W'(ac_ff) <<< 2);
            state_in = S_PICK;
         end
         S_PICK: begin
            if (coef_quad == '0) begin
               if (coef_lin == '0) begin
                  count_in = (coef_const == '0) ? COUNT_ALL : COUNT_NONE;
                  state_in = S_IDLE;
               end else begin
                  count_in  = COUNT_ONE;
                  pass_in   = PASS_LIN;
                  neg_in    = num_lin[NUM_W-1] ^ den_lin[NUM_W-1];
                  dvd_in    = {mag(num_lin), 16'b0};
                  dvs_in    = mag(den_lin);
                  rem_in    = '0;
                  quot_in   = '0;
                  dv_cnt_in = 6'(DIV_STEPS);
                  state_in  = S_DIV;
               end
            end else if (disc_ff[DISC_W-1]) begin
               count_in = COUNT_NONE;
               state_in = S_IDLE;
            end else begin
               count_in  = (disc_ff == '0) ? COUNT_ONE : COUNT_TWO;
               n_in      = disc_ff[SQ_W-1:0];
               res_in    = '0;
               bit_in    = SQ_W'(1) << (SQ_W - 2);
               sq_cnt_in = 5'(SQ_STEPS);
               state_in  = S_SQRT;
            end
         end
         S_SQRT: begin
            if (sq_cnt_ff != '0) begin
               if (n_ff >= sq_sum) begin
                  n_in   = n_ff - sq_sum;
                  res_in = (res_ff >> 1) + bit_ff;
               end else begin
                  res_in = res_ff >> 1;
               end
               bit_in    = bit_ff >> 2;
               sq_cnt_in = sq_cnt_ff - 5'd1;
            end else begin
               pass_in   = PASS_LO;
               neg_in    = num_lo[NUM_W-1] ^ den_quad[NUM_W-1];
               dvd_in    = {mag(num_lo), 16'b0};
               dvs_in    = mag(den_quad);
               rem_in    = '0;
               quot_in   = '0;
               dv_cnt_in = 6'(DIV_STEPS);
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (dv_cnt_ff != '0) begin
               if (rem_sh >= {1'b0, dvs_ff}) begin
                  rem_in  = MAG_W'(rem_sh - {1'b0, dvs_ff});
                  quot_in = {quot_ff[DVD_W-2:0], 1'b1};
               end else begin
                  rem_in  = rem_sh[MAG_W-1:0];
                  quot_in = {quot_ff[DVD_W-2:0], 1'b0};
               end
               dvd_in    = dvd_ff << 1;
               dv_cnt_in = dv_cnt_ff - 6'd1;
            end else begin
               case (pass_ff)
                  PASS_LO: begin
                     low_in    = quot_sat;
                     pass_in   = PASS_HI;
                     neg_in    = num_hi[NUM_W-1] ^ den_quad[NUM_W-1];
                     dvd_in    = {mag(num_hi), 16'b0};
                     dvs_in    = mag(den_quad);
                     rem_in    = '0;
                     quot_in   = '0;
                     dv_cnt_in = 6'(DIV_STEPS);
                  end
                  PASS_HI: begin
                     high_in  = quot_sat;
                     state_in = S_IDLE;
                  end
                  default: begin
                     low_in   = quot_sat;
                     high_in  = quot_sat;
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // A write in the middle of a run starts the solver again, so the
      // roots always follow the last coefficient written.
      if (start) begin
         state_in = S_MUL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= COUNT_ALL;
         low_ff   <= '0;
         high_ff  <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         low_ff   <= low_in;
         high_ff  <= high_in;
      end
   end

   always_ff @(posedge clock) begin
      pass_ff   <= pass_in;
      bb_ff     <= bb_in;
      ac_ff     <= ac_in;
      disc_ff   <= disc_in;
      n_ff      <= n_in;
      res_ff    <= res_in;
      bit_ff    <= bit_in;
      sq_cnt_ff <= sq_cnt_in;
      neg_ff    <= neg_in;
      dvd_ff    <= dvd_in;
      quot_ff   <= quot_in;
      dvs_ff    <= dvs_in;
      rem_ff    <= rem_in;
      dv_cnt_ff <= dv_cnt_in;
   end

   assign info.busy  = (state_ff != S_IDLE);
   assign info.count = count_ff;
   assign info.low   = low_ff;
   assign info.high  = high_ff;

`ifndef SYNTHESIS
   a_idle_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !start) |=>
         ($stable(count_ff) && $stable(low_ff) && $stable(high_ff)))
      else $error("root results changed while the solver was idle");
   a_no_root_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && (count_ff == COUNT_NONE || count_ff == COUNT_ALL)) |->
         (low_ff == '0 && high_ff == '0))
      else $error("roots not zero although none are defined");
   a_one_root_same: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && count_ff == COUNT_ONE && coef_quad == '0) |->
         (low_ff == high_ff))
      else $error("linear root differs between the two outputs");
`endif

endmodule

[rtl/quadratic_eval_and_roots.sv]
// Quadratic evaluator and root finder.
// The coefficients a, b and c (signed Q8.8) are written through the csr_ port:
// csr_we high at a rising edge writes csr_wdata to the register csr_index
// selects (0 = a, 1 = b, 2 = c); other indexes are ignored. Each write
// (re)starts the root solver, which holds req_ready low for its run. The run
// passes the set-up states MUL, DISC and PICK; when a is nonzero and the
// discriminant is not negative it goes on to the bit-serial square root with
// its 17 steps and the one-bit-per-cycle divider, once for each root; in the
// linear case only the divider follows, once; otherwise the run ends there.
// Each req_ item carries x_value (signed Q8.8) and yields one rsp_ item with
// p(x) in signed Q32.16, the root count and both roots in signed Q16.16.
// Items pass a chain of three registered cells; results leave the third. One
// item per cycle is sustained while rsp_ready is high and no write or run is
// under way. The roots depend only on the coefficients, fixed between runs.
// When the receiver holds rsp_ready low, the last cell keeps its item and
// the cells in front of it go on filling, so up to two further items are
// accepted before req_ready falls.
// Reset clears the coefficients to zero (every x is a root, count 3) and
// empties the chain.
module quadratic_eval_and_roots (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [qer_pkg::COEF_W-1:0]   req_x_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [qer_pkg::POLY_W-1:0]   rsp_poly_value,
   output logic [qer_pkg::COUNT_W-1:0]         rsp_root_count,
   output logic signed [qer_pkg::ROOT_W-1:0]   rsp_root_low,
   output logic signed [qer_pkg::ROOT_W-1:0]   rsp_root_high,
   input  logic                                csr_we,
   input  logic [qer_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [qer_pkg::COEF_W-1:0]          csr_wdata
);
   import qer_pkg::*;

   // Coefficient registers.
   logic signed [COEF_W-1:0] coef_quad_ff, coef_quad_in;
   logic signed [COEF_W-1:0] coef_lin_ff, coef_lin_in;
   logic signed [COEF_W-1:0] coef_const_ff, coef_const_in;

   always_comb begin
      coef_quad_in  = coef_quad_ff;
      coef_lin_in   = coef_lin_ff;
      coef_const_in = coef_const_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_COEF_QUAD:  coef_quad_in  = signed'(csr_wdata);
            CSR_COEF_LIN:   coef_lin_in   = signed'(csr_wdata);
            CSR_COEF_CONST: coef_const_in = signed'(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_quad_ff  <= '0;
         coef_lin_ff   <= '0;
         coef_const_ff <= '0;
      end else begin
         coef_quad_ff  <= coef_quad_in;
         coef_lin_ff   <= coef_lin_in;
         coef_const_ff <= coef_const_in;
      end
   end

   // Root solver, restarted by every write.
   root_info_type roots;

   qer_solver u_solver (
      .clock      (clock),
      .reset      (reset),
      .start      (csr_we),
      .coef_quad  (coef_quad_ff),
      .coef_lin   (coef_lin_ff),
      .coef_const (coef_const_ff),
      .info       (roots)
   );

   // Evaluation chain. The first cell holds x with a*x and b*x, the second
   // the exact sum with 24 fraction bits, the third the value rounded down.
   prod_stage_type prod_in, prod_out;
   sum_stage_type  sum_in, sum_out;
   out_stage_type  fin_in, fin_out;
   logic           c1_ready, c1_valid, c2_ready, c2_valid;
   logic           c1_in_ready;
   logic signed [POLY_W-1:0] axx;

   assign req_ready = c1_in_ready && !roots.busy && !csr_we;

   assign prod_in.x  = req_x_value;
   assign prod_in.ax = (2*COEF_W)'(coef_quad_ff) * (2*COEF_W)'(req_x_value);
   assign prod_in.bx = (2*COEF_W)'(coef_lin_ff) * (2*COEF_W)'(req_x_value);

   qer_cell #(.WIDTH($bits(prod_stage_type))) u_cell_prod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid && req_ready),
      .in_ready  (c1_in_ready),
      .in_data   (prod_in),
      .out_valid (c1_valid),
      .out_ready (c1_ready),
      .out_data  (prod_out)
   );

   assign axx = POLY_W'(prod_out.ax) * POLY_W'(prod_out.x);
   assign sum_in.total = axx + (POLY_W'(prod_out.bx) <<< 8)
                       + (POLY_W'(coef_const_ff) <<< 16);

   qer_cell #(.WIDTH($bits(sum_stage_type))) u_cell_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c1_valid),
      .in_ready  (c1_ready),
      .in_data   (sum_in),
      .out_valid (c2_valid),
      .out_ready (c2_ready),
      .out_data  (sum_out)
   );

   // An arithmetic shift rounds toward minus infinity.
   assign fin_in.poly = sum_out.total >>> 8;

   qer_cell #(.WIDTH($bits(out_stage_type))) u_cell_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (c2_valid),
      .in_ready  (c2_ready),
      .in_data   (fin_in),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (fin_out)
   );

   assign rsp_poly_value = fin_out.poly;
   assign rsp_root_count = roots.count;
   assign rsp_root_low   = roots.low;
   assign rsp_root_high  = roots.high;

`ifndef SYNTHESIS
   a_busy_blocks: assert property (@(posedge clock) disable iff (reset)
      roots.busy |-> !req_ready)
      else $error("item accepted while the root solver runs");
   a_write_starts: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> roots.busy)
      else $error("write did not start the root solver");
   a_chain_order: assert property (@(posedge clock) disable iff (reset)
      (c2_valid && !c2_ready) |-> rsp_valid)
      else $error("middle cell stalled with an empty output cell");
`endif

endmodule

[test/tb_quadratic_eval_and_roots.sv]
// Testbench for the quadratic evaluator and root finder.
// The coefficients are loaded through the csr_ port while the block is idle.
// A stream of x items is then pushed through the req_ channel, and every rsp_
// item is checked field by field against a predictor. The run goes through a
// fixed list of coefficient settings that covers each special case of the
// root finder, followed by random settings. The flow control on both sides
// changes from phase to phase.
module tb_quadratic_eval_and_roots;
   import qer_pkg::*;

   // One expected result item, at the widths of the result ports.
   typedef struct {
      logic [POLY_W-1:0]  poly;
      logic [COUNT_W-1:0] count;
      logic [ROOT_W-1:0]  low;
      logic [ROOT_W-1:0]  high;
   } quad_result_type;

   // Keeps a copy of the coefficients, predicts the result of each accepted
   // item and compares the results in order of arrival.
   class quad_scoreboard;
      logic signed [COEF_W-1:0] coef_a, coef_b, coef_c;
      quad_result_type          awaited[$];
      int                       errors;

      function new();
         coef_a = 0;
         coef_b = 0;
         coef_c = 0;
         errors = 0;
      endfunction

      function void set_coef(logic [CSR_INDEX_W-1:0] idx, logic [COEF_W-1:0] v);
         case (idx)
            CSR_COEF_QUAD:  coef_a = v;
            CSR_COEF_LIN:   coef_b = v;
            CSR_COEF_CONST: coef_c = v;
            default: ;
         endcase
      endfunction

      // Integer square root, rounded down, by the digit-pair method.
      function longint unsigned int_sqrt(longint unsigned n);
         longint unsigned res;
         longint unsigned bitv;
         res  = 0;
         bitv = 64'd1 << 62;
         while (bitv > n) bitv = bitv >> 2;
         while (bitv != 0) begin
            if (n >= res + bitv) begin
               n   = n - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
            bitv = bitv >> 2;
         end
         return res;
      endfunction

      // Quotient in Q16.16, truncated toward zero and saturated to 32 bits.
      function logic [ROOT_W-1:0] root_quotient(longint num, longint den);
         longint q;
         q = (num * 65536) / den;
         if (q > 64'sd2147483647) q = 64'sd2147483647;
         if (q < -64'sd2147483648) q = -64'sd2147483648;
         return q[ROOT_W-1:0];
      endfunction

      function void note_input(logic signed [COEF_W-1:0] x_in);
         quad_result_type r;
         longint a, b, c, x, total, disc, s;
         a = coef_a;
         b = coef_b;
         c = coef_c;
         x = x_in;
         // All three terms carry 24 fraction bits; the shift rounds down.
         total  = a * x * x + b * x * 256 + c * 65536;
         total  = total >>> 8;
         r.poly = total[POLY_W-1:0];
         r.low  = '0;
         r.high = '0;
         if (a == 0) begin
            if (b == 0) begin
               r.count = (c == 0) ? COUNT_ALL : COUNT_NONE;
            end else begin
               r.count = COUNT_ONE;
               r.low   = root_quotient(-c, b);
               r.high  = r.low;
            end
         end else begin
            disc = b * b - 4 * a * c;
            if (disc < 0) begin
               r.count = COUNT_NONE;
            end else begin
               s       = longint'(int_sqrt(longint'(disc)));
               r.count = (disc == 0) ? COUNT_ONE : COUNT_TWO;
               r.low   = root_quotient(-b - s, 2 * a);
               r.high  = root_quotient(-b + s, 2 * a);
            end
         end
         awaited.push_back(r);
      endfunction

      function void check_result(logic [POLY_W-1:0] poly, logic [COUNT_W-1:0] count,
                                 logic [ROOT_W-1:0] low, logic [ROOT_W-1:0] high);
         quad_result_type e;
         if (awaited.size() == 0) begin
            $error("result item with no expectation waiting");
            errors++;
            return;
         end
         e = awaited.pop_front();
         if (poly !== e.poly) begin
            $error("poly_value expected %0h actual %0h", e.poly, poly);
            errors++;
         end
         if (count !== e.count) begin
            $error("root_count expected %0d actual %0d", e.count, count);
            errors++;
         end
         if (low !== e.low) begin
            $error("root_low expected %0h actual %0h", e.low, low);
            errors++;
         end
         if (high !== e.high) begin
            $error("root_high expected %0h actual %0h", e.high, high);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic signed [COEF_W-1:0]  req_x_value;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic signed [POLY_W-1:0]  rsp_poly_value;
   logic [COUNT_W-1:0]        rsp_root_count;
   logic signed [ROOT_W-1:0]  rsp_root_low;
   logic signed [ROOT_W-1:0]  rsp_root_high;
   logic                      csr_we;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [COEF_W-1:0]         csr_wdata;

   quad_scoreboard sb = new();

   // Flow control of the current phase: 0 none, 1 sender idles, 2 receiver
   // stalls, 3 both.
   int  flow_mode = 0;
   int  quiet_cycles = 0;
   localparam int WATCHDOG_LIMIT = 3000;

   quadratic_eval_and_roots dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_x_value    (req_x_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_poly_value (rsp_poly_value),
      .rsp_root_count (rsp_root_count),
      .rsp_root_low   (rsp_root_low),
      .rsp_root_high  (rsp_root_high),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // The receiver stalls at random in the phases that call for it. The
   // decision is redrawn every cycle, so stalls fall on every stage.
   always @(posedge clock) begin
      if (flow_mode >= 2) begin
         rsp_ready <= ($urandom_range(99) >= 74);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Handshakes are sampled at the edge, before any of this step's updates
   // have landed, so what is seen here is what the block saw.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.note_input(req_x_value);
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_poly_value, rsp_root_count, rsp_root_low, rsp_root_high);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_quadratic_eval_and_roots: errors");
            $finish;
         end
      end
   end

   // Offers one item and returns at the edge at which it is taken. In an
   // idling phase the sender drops valid for a random number of cycles first;
   // otherwise valid stays high from one item to the next.
   task automatic send_x(logic signed [COEF_W-1:0] x);
      if (flow_mode == 1 || flow_mode == 3) begin
         while ($urandom_range(99) < 74) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid   <= 1'b1;
      req_x_value <= x;
      do @(posedge clock); while (!req_ready);
   endtask

   // Lets every outstanding item come back, then a few cycles more so the
   // chain is certainly empty before the coefficients change.
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_coefs(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                              logic [COEF_W-1:0] c);
      csr_we    <= 1'b1;
      csr_index <= CSR_COEF_QUAD;
      csr_wdata <= a;
      sb.set_coef(CSR_COEF_QUAD, a);
      @(posedge clock);
      csr_index <= CSR_COEF_LIN;
      csr_wdata <= b;
      sb.set_coef(CSR_COEF_LIN, b);
      @(posedge clock);
      csr_index <= CSR_COEF_CONST;
      csr_wdata <= c;
      sb.set_coef(CSR_COEF_CONST, c);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // One phase: the extremes, 0, 1 and -1, then random points. About one
   // random item in four is small, so points near the roots are also visited.
   task automatic run_phase(int n_random);
      send_x(16'sh8000);
      send_x(16'sh7fff);
      send_x(16'sh0000);
      send_x(-16'sd1);
      send_x(16'sd1);
      for (int i = 0; i < n_random; i++) begin
         if ($urandom_range(3) == 0) begin
            send_x(COEF_W'($urandom_range(2047) - 1024));
         end else begin
            send_x(COEF_W'($urandom()));
         end
      end
      drain();
   endtask

   // Coefficient settings, one per phase. They cover a double root, no real
   // roots, the linear case, a nonzero constant, the extreme coefficients,
   // saturated roots, a negative leading coefficient and all-zero again.
   logic [COEF_W-1:0] fixed_sets[12][3] = '{
      '{16'd256,    16'd512,    16'd256},
      '{16'd256,    16'd0,      16'd256},
      '{16'd0,      16'd512,    -16'd768},
      '{16'd0,      16'd0,      16'd1000},
      '{16'h8000,   16'h8000,   16'h7fff},
      '{16'h7fff,   16'h7fff,   16'h8000},
      '{16'd1,      16'h7fff,   16'h8000},
      '{-16'd256,   16'd0,      16'd1024},
      '{16'd0,      16'h8000,   16'h8000},
      '{16'd0,      16'd1,      16'h7fff},
      '{16'hffff,   16'hffff,   16'hffff},
      '{16'd0,      16'd0,      16'd0}
   };

   initial begin
      logic [COEF_W-1:0] ca, cb, cc;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_x_value <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_COEF_QUAD;
      csr_wdata   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Straight after reset every coefficient is zero, so every x is a root.
      flow_mode = 0;
      run_phase(50);

      foreach (fixed_sets[k]) begin
         flow_mode = (k + 1) % 4;
         write_coefs(fixed_sets[k][0], fixed_sets[k][1], fixed_sets[k][2]);
         run_phase(50);
      end

      // Random settings. The even ones give a and c opposite signs, which
      // makes real roots likely; every fifth clears a for the linear case.
      for (int p = 0; p < 17; p++) begin
         flow_mode = p % 4;
         ca = COEF_W'($urandom());
         cb = COEF_W'($urandom());
         cc = COEF_W'($urandom());
         if (p % 2 == 0) cc[COEF_W-1] = ~ca[COEF_W-1];
         if (p % 5 == 4) ca = '0;
         write_coefs(ca, cb, cc);
         run_phase(50);
      end

      flow_mode = 0;
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.awaited.size() == 0) begin
         $display("tb_quadratic_eval_and_roots: clean");
      end else begin
         $display("tb_quadratic_eval_and_roots: errors");
      end
      $finish;
   end

endmodule

[quadratic_eval_and_roots.f]
rtl/qer_pkg.sv
rtl/qer_cell.sv
rtl/qer_solver.sv
rtl/quadratic_eval_and_roots.sv
test/tb_quadratic_eval_and_roots.sv
